FILE: rtl/shower_top5_energy_tracker_macros.svh
// Assertion helpers included by the tracker top level.
`ifndef SHOWER_TOP5_ENERGY_TRACKER_MACROS_SVH
`define SHOWER_TOP5_ENERGY_TRACKER_MACROS_SVH

// Checked on every rising edge of clk_i outside reset.
`define SHWT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define SHWT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/shwt_pkg.sv
package shwt_pkg;

  localparam int unsigned EnergyW = 18;
  localparam int unsigned CountW  = 8;
  localparam int unsigned SumW    = 24;
  localparam int unsigned Shown   = 5;

  localparam logic [EnergyW-1:0] CutReset = 18'd529;
  localparam logic [CountW-1:0]  CountMax = 8'd255;
  localparam logic [SumW-1:0]    SumMax   = 24'hFFFFFF;

  // One shower item as held in the input register.
  typedef struct packed {
    logic               present;
    logic [EnergyW-1:0] energy;
    logic               hot;
    logic               status;
    logic               last;
  } shwt_item_t;

endpackage

FILE: rtl/shwt_accum.sv
module shwt_accum #(
  parameter int unsigned TOP_K = 5
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            upd_i,
  input  shwt_pkg::shwt_item_t            item_i,
  input  logic [shwt_pkg::EnergyW-1:0]    cut_i,
  output logic [shwt_pkg::CountW-1:0]     count_o,
  output logic [shwt_pkg::SumW-1:0]       sum_o,
  output logic [shwt_pkg::EnergyW-1:0]    top_o [TOP_K]
);
  import shwt_pkg::*;

  logic [CountW-1:0]  count_q, count_d, count_n;
  logic [SumW-1:0]    sum_q, sum_d, sum_n;
  logic [SumW:0]      sum_wide;
  logic [EnergyW-1:0] top_q [TOP_K];
  logic [EnergyW-1:0] top_d [TOP_K];
  logic [EnergyW-1:0] top_n [TOP_K];
  logic [TOP_K-1:0]   gt;
  logic               good;

  assign good = item_i.present && !item_i.hot && item_i.status && (item_i.energy > cut_i);

  assign sum_wide = {1'b0, sum_q} + {{(SumW+1-EnergyW){1'b0}}, item_i.energy};
  assign sum_n    = sum_wide[SumW] ? SumMax : sum_wide[SumW-1:0];
  assign count_n  = (count_q == CountMax) ? count_q : count_q + 8'd1;

  // The kept list is descending, so gt is a thermometer code: the first set
  // bit is the insert slot and every slot below it shifts down by one.
  for (genvar i = 0; i < TOP_K; i++) begin : g_slot
    assign gt[i] = item_i.energy > top_q[i];
    if (i == 0) begin : g_head
      assign top_n[i] = gt[i] ? item_i.energy : top_q[i];
    end else begin : g_tail
      assign top_n[i] = !gt[i] ? top_q[i] : (gt[i-1] ? top_q[i-1] : item_i.energy);
    end
    assign top_o[i] = good ? top_n[i] : top_q[i];
  end

  assign count_o = good ? count_n : count_q;
  assign sum_o   = good ? sum_n : sum_q;

  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    top_d   = top_q;
    if (upd_i) begin
      if (item_i.last) begin
        // summary goes out this cycle, start the next event empty
        count_d = '0;
        sum_d   = '0;
        for (int k = 0; k < TOP_K; k++) top_d[k] = '0;
      end else begin
        count_d = count_o;
        sum_d   = sum_o;
        top_d   = top_o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      for (int k = 0; k < TOP_K; k++) top_q[k] <= '0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
      top_q   <= top_d;
    end
  end

endmodule

FILE: rtl/shower_top5_energy_tracker.sv
// Channel | Signals                                   | Direction
// in      | in_valid_i / in_stall_o, five shower fields | shower items in
// out     | out_valid_o / out_stall_i, seven summary fields | one summary per event
// cfg     | cfg_we_i, cfg_wdata_i                     | energy cut write
// An item enters the input register and is then folded into the event state;
// the edge that folds a last item also loads its summary into the result register.
// One item per cycle, except while a stalled summary holds a last item;
// the single-pass compare/shift/add sets the pace.
// Reset clears the event state and loads the cut with 529.
// Only a last item waiting on a full, stalled result register holds the input.
module shower_top5_energy_tracker #(
  parameter int unsigned TOP_K = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [shwt_pkg::EnergyW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          present_i,
  input  logic [shwt_pkg::EnergyW-1:0]  shower_energy_i,
  input  logic                          hot_flag_i,
  input  logic                          status_ok_i,
  input  logic                          event_end_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [shwt_pkg::CountW-1:0]   good_count_o,
  output logic [shwt_pkg::SumW-1:0]     energy_total_o,
  output logic [shwt_pkg::EnergyW-1:0]  largest1_o,
  output logic [shwt_pkg::EnergyW-1:0]  largest2_o,
  output logic [shwt_pkg::EnergyW-1:0]  largest3_o,
  output logic [shwt_pkg::EnergyW-1:0]  largest4_o,
  output logic [shwt_pkg::EnergyW-1:0]  largest5_o
);
  import shwt_pkg::*;

  `include "shower_top5_energy_tracker_macros.svh"

  logic [EnergyW-1:0] cut_q;
  logic               s1_valid_q;
  shwt_item_t         s1_q;
  logic               hold;
  logic               upd;
  logic               load;

  logic [CountW-1:0]  acc_count;
  logic [SumW-1:0]    acc_sum;
  logic [EnergyW-1:0] acc_top [TOP_K];
  logic [EnergyW-1:0] shown [Shown];

  logic               out_valid_q;
  logic [CountW-1:0]  count_q;
  logic [SumW-1:0]    sum_q;
  logic [EnergyW-1:0] big_q [Shown];

  // Hold a last item while the previous summary is still stalled.
  assign hold       = s1_valid_q && s1_q.last && out_valid_q && out_stall_i;
  assign in_stall_o = hold;
  assign upd        = s1_valid_q && !hold;
  assign load       = upd && s1_q.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cut_q <= CutReset;
    end else if (cfg_we_i) begin
      cut_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!hold) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !hold) begin
      s1_q.present <= present_i;
      s1_q.energy  <= shower_energy_i;
      s1_q.hot     <= hot_flag_i;
      s1_q.status  <= status_ok_i;
      s1_q.last    <= event_end_i;
    end
  end

  shwt_accum #(
    .TOP_K (TOP_K)
  ) u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (upd),
    .item_i  (s1_q),
    .cut_i   (cut_q),
    .count_o (acc_count),
    .sum_o   (acc_sum),
    .top_o   (acc_top)
  );

  for (genvar i = 0; i < Shown; i++) begin : g_shown
    if (i < TOP_K) begin : g_kept
      assign shown[i] = acc_top[i];
    end else begin : g_pad
      assign shown[i] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      count_q <= acc_count;
      sum_q   <= acc_sum;
      big_q   <= shown;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign good_count_o   = count_q;
  assign energy_total_o = sum_q;
  assign largest1_o     = big_q[0];
  assign largest2_o     = big_q[1];
  assign largest3_o     = big_q[2];
  assign largest4_o     = big_q[3];
  assign largest5_o     = big_q[4];

  `SHWT_ASSERT(a_stall_cause, in_stall_o |-> (out_valid_o && out_stall_i && s1_valid_q), "input held without a stalled summary")
  `SHWT_ASSERT(a_rise_on_last, $rose(out_valid_o) |-> $past(s1_valid_q && s1_q.last), "summary without a last item")
  `SHWT_ASSERT(a_descending, out_valid_o |-> (largest1_o >= largest2_o && largest2_o >= largest3_o && largest3_o >= largest4_o && largest4_o >= largest5_o), "summary energies out of order")
  `SHWT_ASSERT(a_empty_event, (out_valid_o && good_count_o == '0) |-> (energy_total_o == '0 && largest1_o == '0), "empty event with nonzero energy")
  `SHWT_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o, "summary valid during reset")

endmodule

FILE: tb/sv/shower_top5_energy_tracker_tb.sv
`timescale 1ns / 100ps

module shower_top5_energy_tracker_tb;
  import shwt_pkg::*;

  localparam int unsigned TopK         = 5;
  localparam int unsigned FieldMax     = (1 << EnergyW) - 1;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned QuietLimit   = 4000;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned DirRows      = 18;
  localparam int unsigned SatShowers   = 300;

  typedef struct packed {
    logic [CountW-1:0]                count;
    logic [SumW-1:0]                  total;
    logic [Shown-1:0][EnergyW-1:0]    largest;
  } summary_t;

  logic                clk_i;
  logic                rst_ni          = 1'b0;
  logic                cfg_we_i        = 1'b0;
  logic [EnergyW-1:0]  cfg_wdata_i     = '0;
  logic                in_valid_i      = 1'b0;
  logic                in_stall_o;
  logic                present_i       = 1'b0;
  logic [EnergyW-1:0]  shower_energy_i = '0;
  logic                hot_flag_i      = 1'b0;
  logic                status_ok_i     = 1'b0;
  logic                event_end_i     = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i     = 1'b0;
  logic [CountW-1:0]   good_count_o;
  logic [SumW-1:0]     energy_total_o;
  logic [EnergyW-1:0]  largest1_o;
  logic [EnergyW-1:0]  largest2_o;
  logic [EnergyW-1:0]  largest3_o;
  logic [EnergyW-1:0]  largest4_o;
  logic [EnergyW-1:0]  largest5_o;

  logic [Shown-1:0][EnergyW-1:0] shown_top;
  assign shown_top = {largest5_o, largest4_o, largest3_o, largest2_o, largest1_o};

  shower_top5_energy_tracker #(
    .TOP_K(TopK)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .present_i      (present_i),
    .shower_energy_i(shower_energy_i),
    .hot_flag_i     (hot_flag_i),
    .status_ok_i    (status_ok_i),
    .event_end_i    (event_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .good_count_o   (good_count_o),
    .energy_total_o (energy_total_o),
    .largest1_o     (largest1_o),
    .largest2_o     (largest2_o),
    .largest3_o     (largest3_o),
    .largest4_o     (largest4_o),
    .largest5_o     (largest5_o)
  );

  // present, energy, hot, status, last, count (-1: predicted), total, largest1
  int dir_rows [DirRows][8] = '{
    '{0, 0,      0, 0, 1,  0, 0,      0},       // end marker right after reset
    '{1, 530,    0, 1, 1,  1, 530,    530},     // one step above the cut
    '{1, 529,    0, 1, 1,  0, 0,      0},       // energy equal to the cut
    '{1, 262143, 1, 1, 1,  0, 0,      0},       // hot shower
    '{1, 262143, 0, 0, 1,  0, 0,      0},       // bad status
    '{0, 262143, 0, 1, 1,  0, 0,      0},       // empty item ignores its fields
    '{1, 262143, 0, 1, 1,  1, 262143, 262143},  // largest energy
    '{1, 0,      0, 1, 0, -1, 0,      0},
    '{1, 1000,   0, 1, 0, -1, 0,      0},
    '{1, 3000,   0, 1, 0, -1, 0,      0},
    '{1, 2000,   0, 1, 0, -1, 0,      0},
    '{1, 3000,   0, 1, 0, -1, 0,      0},       // tie keeps the earlier value first
    '{0, 77777,  1, 0, 0, -1, 0,      0},       // empty item inside the event
    '{1, 5000,   0, 1, 0, -1, 0,      0},
    '{1, 4000,   0, 1, 0, -1, 0,      0},
    '{1, 600,    0, 1, 0, -1, 0,      0},       // below all five kept, drops out
    '{1, 3000,   1, 1, 0, -1, 0,      0},
    '{1, 700,    0, 1, 1, -1, 0,      0}        // last item carries a shower
  };

  // Event state mirrored by the testbench
  logic [EnergyW-1:0] cut_model = CutReset;
  int unsigned        good_seen;
  int unsigned        energy_seen;
  logic [EnergyW-1:0] ranked [TopK];

  summary_t    pending_summaries [$];
  summary_t    head;
  int unsigned mismatch_count = 0;
  int unsigned idle_pct       = 0;
  int unsigned stall_pct      = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned hold_left      = 0;
  bit          hold_req       = 1'b0;
  bit          hold_seen      = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  task automatic clear_event_model();
    good_seen   = 0;
    energy_seen = 0;
    for (int i = 0; i < TopK; i++) ranked[i] = '0;
  endtask

  task automatic fold_shower(input shwt_item_t it, output bit emits, output summary_t want);
    int unsigned slot;
    slot = TopK;
    if (it.present && !it.hot && it.status && it.energy > cut_model) begin
      if (good_seen < CountMax) good_seen++;
      energy_seen += it.energy;
      if (energy_seen > SumMax) energy_seen = 32'(SumMax);
      // strict compare: a tie leaves the earlier value above
      for (int i = 0; i < TopK; i++) begin
        if (slot == TopK && it.energy > ranked[i]) slot = i;
      end
      for (int i = TopK - 1; i > slot; i--) ranked[i] = ranked[i - 1];
      if (slot < TopK) ranked[slot] = it.energy;
    end
    emits = it.last;
    want  = '0;
    if (it.last) begin
      want.count = good_seen[CountW-1:0];
      want.total = energy_seen[SumW-1:0];
      for (int i = 0; i < Shown; i++) begin
        if (i < TopK) want.largest[i] = ranked[i];
      end
      clear_event_model();
    end
  endtask

  function automatic logic [EnergyW-1:0] pick_energy();
    int unsigned lo;
    int unsigned hi;
    case ($urandom_range(3))
      0: return EnergyW'($urandom_range(FieldMax, 0));
      1: begin
        lo = (cut_model > 2) ? cut_model - 2 : 0;
        hi = (cut_model + 2 > FieldMax) ? FieldMax : cut_model + 2;
        return EnergyW'($urandom_range(hi, lo));
      end
      default: begin
        hi = (cut_model * 4 + 1000 > FieldMax) ? FieldMax : cut_model * 4 + 1000;
        return EnergyW'($urandom_range(hi, 0));
      end
    endcase
  endfunction

  task automatic push_shower(input shwt_item_t it, output bit emits, output summary_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    present_i       <= it.present;
    shower_energy_i <= it.energy;
    hot_flag_i      <= it.hot;
    status_ok_i     <= it.status;
    event_end_i     <= it.last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    fold_shower(it, emits, want);
  endtask

  task automatic send_event(input int unsigned showers);
    shwt_item_t it;
    summary_t   want;
    bit         emits;
    for (int unsigned k = 0; k <= showers; k++) begin
      it.present = ($urandom_range(9) != 0);
      it.energy  = pick_energy();
      it.hot     = ($urandom_range(6) == 0);
      it.status  = ($urandom_range(7) != 0);
      it.last    = (k == showers);
      if (it.last && $urandom_range(3) == 0) it.present = 1'b0;
      push_shower(it, emits, want);
      if (emits) pending_summaries.push_back(want);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_summaries.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_cut(input logic [EnergyW-1:0] cut);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cut;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cut_model = cut;
  endtask

  task automatic run_phase(input logic [EnergyW-1:0] cut, input int unsigned idle,
                           input int unsigned stall, input int unsigned items,
                           input bit hold);
    int unsigned sent;
    int unsigned showers;
    bit          fired;
    sent  = 0;
    fired = 1'b0;
    write_cut(cut);
    idle_pct  = idle;
    stall_pct <= stall;
    while (sent < items) begin
      // hold the result side off while items keep coming
      if (hold && !fired && sent >= 20) begin
        hold_req <= ~hold_req;
        fired = 1'b1;
      end
      showers = $urandom_range(12);
      send_event(showers);
      sent += showers + 1;
    end
  endtask

  initial begin : stimulus
    shwt_item_t it;
    summary_t   want;
    bit         emits;
    clear_event_model();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DirRows; r++) begin
      it.present = 1'(dir_rows[r][0]);
      it.energy  = EnergyW'(dir_rows[r][1]);
      it.hot     = 1'(dir_rows[r][2]);
      it.status  = 1'(dir_rows[r][3]);
      it.last    = 1'(dir_rows[r][4]);
      push_shower(it, emits, want);
      if (emits && dir_rows[r][5] >= 0) begin
        want            = '0;
        want.count      = CountW'(dir_rows[r][5]);
        want.total      = SumW'(dir_rows[r][6]);
        want.largest[0] = EnergyW'(dir_rows[r][7]);
      end
      if (emits) pending_summaries.push_back(want);
    end

    run_phase(EnergyW'($urandom_range(40000)), 0, 0, 100, 1'b0);
    run_phase('0, 56, 0, 100, 1'b0);

    // one long event to saturate both the count and the sum
    for (int k = 0; k < SatShowers; k++) begin
      it.present = 1'b1;
      it.energy  = EnergyW'($urandom_range(FieldMax, 200000));
      it.hot     = 1'b0;
      it.status  = 1'b1;
      it.last    = (k == SatShowers - 1);
      push_shower(it, emits, want);
      if (emits) pending_summaries.push_back(want);
    end

    run_phase(EnergyW'(FieldMax), 0, 56, 60, 1'b0);
    run_phase(EnergyW'($urandom_range(5000)), 34, 34, 100, 1'b1);
    run_phase(EnergyW'(1), 56, 0, 80, 1'b0);
    run_phase(CutReset, 0, 56, 100, 1'b1);
    run_phase(EnergyW'($urandom_range(FieldMax)), 34, 34, 80, 1'b0);

    drain_results();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen   <= hold_req;
      hold_left   <= HoldCycles;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_summaries.size() == 0) begin
        report_mismatch("summary with no event pending", 32'(good_count_o), 0);
      end else begin
        head = pending_summaries.pop_front();
        if (good_count_o !== head.count)
          report_mismatch("good_count", 32'(good_count_o), 32'(head.count));
        if (energy_total_o !== head.total)
          report_mismatch("energy_total", 32'(energy_total_o), 32'(head.total));
        for (int i = 0; i < Shown; i++) begin
          if (shown_top[i] !== head.largest[i])
            report_mismatch($sformatf("largest%0d", i + 1), 32'(shown_top[i]),
                            32'(head.largest[i]));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
